[src/mbsv_pkg.sv]
// Shared types and constants for the multiaddr binary stream validator.
// No dependencies; imported by mbsv_byte_queue, mbsv_parser and the top level.
package mbsv_pkg;

	// byte roles reported on each result
	localparam logic [1:0] ROLE_CODE = 2'd0;
	localparam logic [1:0] ROLE_LEN  = 2'd1;
	localparam logic [1:0] ROLE_ADDR = 2'd2;
	localparam logic [1:0] ROLE_IGN  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// protocol codes (multicodec)
	localparam logic [15:0] P_IP4     = 16'h0004;
	localparam logic [15:0] P_TCP     = 16'h0006;
	localparam logic [15:0] P_IP6     = 16'h0029;
	localparam logic [15:0] P_DNS     = 16'h0035;
	localparam logic [15:0] P_DNS4    = 16'h0036;
	localparam logic [15:0] P_DNS6    = 16'h0037;
	localparam logic [15:0] P_DNSADDR = 16'h0038;
	localparam logic [15:0] P_UDP     = 16'h0111;
	localparam logic [15:0] P_CIRCUIT = 16'h0122;
	localparam logic [15:0] P_P2P     = 16'h01a5;
	localparam logic [15:0] P_QUIC    = 16'h01cc;
	localparam logic [15:0] P_QUICV1  = 16'h01cd;
	localparam logic [15:0] P_WS      = 16'h01dd;
	localparam logic [15:0] P_WSS     = 16'h01de;

	// address length classes
	localparam logic [1:0] LC_UNKNOWN = 2'd0;
	localparam logic [1:0] LC_FIXED   = 2'd1;
	localparam logic [1:0] LC_ZERO    = 2'd2;
	localparam logic [1:0] LC_VAR     = 2'd3;

	// classified input byte as it sits in the queue
	typedef struct packed {
		logic [6:0] payload;
		logic       cont;
		logic       last;
	} item_t;

	function automatic logic [1:0] len_class(input logic [15:0] code);
		logic [1:0] c;
		case (code)
			P_IP4, P_IP6, P_TCP, P_UDP:                          c = LC_FIXED;
			P_WS, P_WSS, P_QUIC, P_QUICV1, P_CIRCUIT:            c = LC_ZERO;
			P_DNS, P_DNS4, P_DNS6, P_DNSADDR, P_P2P:             c = LC_VAR;
			default:                                             c = LC_UNKNOWN;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] fixed_len(input logic [15:0] code);
		logic [4:0] n;
		case (code)
			P_IP4:   n = 5'd4;
			P_IP6:   n = 5'd16;
			P_TCP:   n = 5'd2;
			P_UDP:   n = 5'd2;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

[src/mbsv_byte_queue.sv]
// Front end: accepts raw bytes, splits off the continuation bit, and holds
// them in a two-entry queue for the parser. Depends on mbsv_pkg.
module mbsv_byte_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          byte_value,
	input  logic                last_byte,
	output logic                q_valid,
	output mbsv_pkg::item_t     q_item,
	input  logic                q_pop
);
	import mbsv_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      item_in;

	assign item_in.payload = byte_value[6:0];
	assign item_in.cont    = byte_value[7];
	assign item_in.last    = last_byte;

	assign byte_stall = (count_q == 2'd2);
	assign push       = byte_valid && !byte_stall;
	assign q_valid    = (count_q != 2'd0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |=> (count_q <= 2'd1)) else $error("queue grew by two");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> q_valid) else $error("stall with empty queue");

endmodule

[src/mbsv_parser.sv]
// Back end: pops classified bytes, runs the multiaddr parse state and
// registers one tagged result per byte. Depends on mbsv_pkg.
module mbsv_parser #(
	parameter int unsigned MAX_ADDRESS_BYTES = 65535,
	parameter int unsigned MAX_COMPONENTS    = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  mbsv_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          byte_role,
	output logic [7:0]          component_number,
	output logic [15:0]         protocol_code,
	output logic [15:0]         address_offset,
	output logic                component_end,
	output logic [1:0]          status,
	output logic                address_done,
	output logic [7:0]          protocol_count
);
	import mbsv_pkg::*;

	localparam logic [1:0]  PH_CODE = 2'd0;
	localparam logic [1:0]  PH_LEN  = 2'd1;
	localparam logic [1:0]  PH_ADDR = 2'd2;
	localparam logic [1:0]  PH_ERR  = 2'd3;
	localparam logic [15:0] MAX_LEN  = MAX_ADDRESS_BYTES[15:0];
	localparam logic [7:0]  MAX_COMP = MAX_COMPONENTS[7:0];

	// parse state
	logic [1:0]  phase_q,  phase_n;
	logic [15:0] acc_lo_q, acc_lo_n;   // low 16 bits of the varint
	logic        acc_hi_q, acc_hi_n;   // any bit above 15 set
	logic [3:0]  vcnt_q,   vcnt_n;
	logic [15:0] code_q,   code_n;
	logic [15:0] rem_q,    rem_n;
	logic [15:0] off_q,    off_n;
	logic [7:0]  seen_q,   seen_n;
	logic [1:0]  err_q,    err_n;

	// result of this byte
	logic [1:0]  role_c;
	logic [15:0] code_c;
	logic [15:0] off_c;
	logic        cend_c;
	logic [7:0]  count_c;

	// varint step
	logic [15:0] vlo;
	logic        vhi;
	logic        v_bad;
	logic        v_done;
	logic [1:0]  lclass;
	logic        out_free;
	logic        pop;

	assign out_free = !result_valid || !result_stall;
	assign pop      = q_valid && out_free;
	assign q_pop    = out_free;

	// merge this byte's 7 bits into the accumulator at position 7*vcnt
	always_comb begin
		vlo = acc_lo_q;
		vhi = acc_hi_q;
		case (vcnt_q)
			4'd0: vlo = acc_lo_q | {9'd0, q_item.payload};
			4'd1: vlo = acc_lo_q | {2'd0, q_item.payload, 7'd0};
			4'd2: begin
				vlo = acc_lo_q | {q_item.payload[1:0], 14'd0};
				vhi = acc_hi_q | (|q_item.payload[6:2]);
			end
			default: vhi = acc_hi_q | (|q_item.payload);
		endcase
		// ninth byte may not continue; a closing zero byte is non-minimal
		v_bad  = ((vcnt_q >= 4'd8) && q_item.cont) ||
		         (!q_item.cont && (vcnt_q != 4'd0) && (q_item.payload == 7'd0));
		v_done = !q_item.cont && !v_bad;
	end

	assign lclass = len_class(vlo);

	always_comb begin
		phase_n  = phase_q;
		acc_lo_n = acc_lo_q;
		acc_hi_n = acc_hi_q;
		vcnt_n   = vcnt_q;
		code_n   = code_q;
		rem_n    = rem_q;
		off_n    = off_q;
		seen_n   = seen_q;
		err_n    = err_q;
		role_c   = ROLE_IGN;
		code_c   = 16'd0;
		off_c    = 16'd0;
		cend_c   = 1'b0;

		if (err_q == ST_OK) begin
			case (phase_q)
				PH_CODE: begin
					role_c   = ROLE_CODE;
					acc_lo_n = vlo;
					acc_hi_n = vhi;
					vcnt_n   = vcnt_q + 4'd1;
					if (v_bad) begin
						err_n = ST_INVALID;
					end else if (v_done) begin
						acc_lo_n = 16'd0;
						acc_hi_n = 1'b0;
						vcnt_n   = 4'd0;
						if (vhi || lclass == LC_UNKNOWN) begin
							err_n = ST_UNKNOWN;
						end else begin
							code_n = vlo;
							code_c = vlo;
							if (lclass == LC_VAR) begin
								phase_n = PH_LEN;
							end else if (lclass == LC_ZERO) begin
								cend_c = 1'b1;
							end else begin
								phase_n = PH_ADDR;
								rem_n   = {11'd0, fixed_len(vlo)};
								off_n   = 16'd0;
							end
						end
					end
				end
				PH_LEN: begin
					role_c   = ROLE_LEN;
					code_c   = code_q;
					acc_lo_n = vlo;
					acc_hi_n = vhi;
					vcnt_n   = vcnt_q + 4'd1;
					if (v_bad) begin
						err_n = ST_INVALID;
					end else if (v_done) begin
						acc_lo_n = 16'd0;
						acc_hi_n = 1'b0;
						vcnt_n   = 4'd0;
						if (vhi || vlo > MAX_LEN) begin
							err_n = ST_INVALID;
						end else if (vlo == 16'd0) begin
							cend_c = 1'b1;
						end else begin
							phase_n = PH_ADDR;
							rem_n   = vlo;
							off_n   = 16'd0;
						end
					end
				end
				default: begin
					role_c = ROLE_ADDR;
					code_c = code_q;
					off_c  = off_q;
					off_n  = off_q + 16'd1;
					if (rem_q != 16'd0) begin
						rem_n = rem_q - 16'd1;
					end
					if (rem_q <= 16'd1) begin
						cend_c = 1'b1;
					end
				end
			endcase
			if (cend_c) begin
				if (seen_q < MAX_COMP) begin
					seen_n = seen_q + 8'd1;
				end
				phase_n = PH_CODE;
				rem_n   = 16'd0;
				off_n   = 16'd0;
			end
			if (err_n != ST_OK) begin
				phase_n = PH_ERR;
			end
		end

		// truncation: address ends inside a varint or an address value
		if (q_item.last && err_n == ST_OK && (phase_n != PH_CODE || vcnt_n != 4'd0)) begin
			err_n   = ST_INVALID;
			phase_n = PH_ERR;
		end

		count_c = (q_item.last && err_n != ST_OK) ? 8'd0 : seen_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CODE;
			acc_lo_q <= 16'd0;
			acc_hi_q <= 1'b0;
			vcnt_q   <= 4'd0;
			code_q   <= 16'd0;
			rem_q    <= 16'd0;
			off_q    <= 16'd0;
			seen_q   <= 8'd0;
			err_q    <= ST_OK;
		end else if (pop) begin
			if (q_item.last) begin
				phase_q  <= PH_CODE;
				acc_lo_q <= 16'd0;
				acc_hi_q <= 1'b0;
				vcnt_q   <= 4'd0;
				code_q   <= 16'd0;
				rem_q    <= 16'd0;
				off_q    <= 16'd0;
				seen_q   <= 8'd0;
				err_q    <= ST_OK;
			end else begin
				phase_q  <= phase_n;
				acc_lo_q <= acc_lo_n;
				acc_hi_q <= acc_hi_n;
				vcnt_q   <= vcnt_n;
				code_q   <= code_n;
				rem_q    <= rem_n;
				off_q    <= off_n;
				seen_q   <= seen_n;
				err_q    <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_role        <= role_c;
			component_number <= seen_q;
			protocol_code    <= code_c;
			address_offset   <= off_c;
			component_end    <= cend_c;
			status           <= err_n;
			address_done     <= q_item.last;
			protocol_count   <= count_c;
		end
	end

	a_ign_has_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && byte_role == ROLE_IGN) |-> (status != ST_OK))
		else $error("ignored byte without error status");
	a_cend_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && component_end) |-> (status == ST_OK))
		else $error("component end on failing byte");
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && address_done && status != ST_OK) |-> (protocol_count == 8'd0))
		else $error("nonzero count on failed address");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.last) |=> (seen_q == 8'd0 && err_q == ST_OK && phase_q == PH_CODE))
		else $error("state not cleared after last byte");
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) == (phase_q == PH_ERR))
		else $error("error status and phase disagree");

endmodule

[src/multiaddr_binary_stream_validator_top.sv]
// Channel     | valid / stall              | payload
// byte in     | byte_valid / byte_stall    | byte_value[7:0], last_byte
// result out  | result_valid / result_stall| byte_role .. protocol_count
//
// One byte per cycle while result_stall is low; each byte gives one result
// (queue write, then parse into the output register).
// The combinational parse step over the varint/phase state sets the rate.
// arst_n clears the queue, parse state and result valid; no clearing pass.
// A stalled result holds the parser; the two-entry queue keeps taking bytes
// until it is full.
// Top level: instantiates mbsv_byte_queue and mbsv_parser; uses mbsv_pkg.
module multiaddr_binary_stream_validator_top #(
	parameter int unsigned MAX_ADDRESS_BYTES = 65535,
	parameter int unsigned MAX_COMPONENTS    = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  byte_role,
	output logic [7:0]  component_number,
	output logic [15:0] protocol_code,
	output logic [15:0] address_offset,
	output logic        component_end,
	output logic [1:0]  status,
	output logic        address_done,
	output logic [7:0]  protocol_count
);
	import mbsv_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	mbsv_byte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	mbsv_parser #(
		.MAX_ADDRESS_BYTES (MAX_ADDRESS_BYTES),
		.MAX_COMPONENTS    (MAX_COMPONENTS)
	) u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.byte_role        (byte_role),
		.component_number (component_number),
		.protocol_code    (protocol_code),
		.address_offset   (address_offset),
		.component_end    (component_end),
		.status           (status),
		.address_done     (address_done),
		.protocol_count   (protocol_count)
	);

endmodule

[dv/mbsv_parse_checker.sv]
`timescale 1ns / 100ps
// Result checker for the multiaddr binary stream validator: predicts the tag of each byte.
// Watches both channels, compares results in order and reports a failure count.
// Depends on mbsv_pkg.
module mbsv_parse_checker #(
	parameter int unsigned MAX_ADDRESS_BYTES = 65535,
	parameter int unsigned MAX_COMPONENTS    = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [1:0]  byte_role,
	input  logic [7:0]  component_number,
	input  logic [15:0] protocol_code,
	input  logic [15:0] address_offset,
	input  logic        component_end,
	input  logic [1:0]  status,
	input  logic        address_done,
	input  logic [7:0]  protocol_count,
	output int unsigned errors,
	output int unsigned pending
);
	import mbsv_pkg::*;

	localparam int LEN_UNKNOWN  = -1;
	localparam int LEN_VARIABLE = -2;

	typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_ADDR, PH_ERR} phase_e;
	typedef enum logic [1:0] {VI_MORE, VI_DONE, VI_BAD} varint_e;

	typedef struct packed {
		logic [1:0]  role;
		logic [7:0]  comp;
		logic [15:0] code;
		logic [15:0] off;
		logic        cend;
		logic [1:0]  status;
		logic        done;
		logic [7:0]  count;
	} byte_tag_t;

	phase_e      phase;
	logic [63:0] vacc;
	logic [3:0]  vcount;
	logic [15:0] cur_code;
	logic [15:0] remaining;
	logic [15:0] offset;
	logic [7:0]  seen;
	logic [1:0]  fault;

	byte_tag_t expected_tags[$];

	function automatic void clear_parse();
		phase     = PH_CODE;
		vacc      = '0;
		vcount    = '0;
		cur_code  = '0;
		remaining = '0;
		offset    = '0;
		seen      = '0;
		fault     = ST_OK;
	endfunction

	function automatic varint_e varint_take(input logic [7:0] b);
		if (vcount >= 4'd8 && b[7])
			return VI_BAD;
		vacc   = vacc | (64'(b[6:0]) << (7 * vcount));
		vcount = vcount + 4'd1;
		if (b[7])
			return VI_MORE;
		if (vcount > 4'd1 && b == 8'h00)
			return VI_BAD;
		return VI_DONE;
	endfunction

	function automatic void close_component();
		if (seen < MAX_COMPONENTS)
			seen = seen + 8'd1;
		phase     = PH_CODE;
		remaining = '0;
		offset    = '0;
	endfunction

	task automatic predict_byte_tag(input logic [7:0] b, input logic last,
			output byte_tag_t r);
		varint_e     v;
		logic [63:0] val;
		int          len;
		logic [1:0]  err;
		r      = '0;
		r.role = ROLE_IGN;
		r.comp = seen;
		err    = ST_OK;
		if (fault == ST_OK) begin
			case (phase)
				PH_CODE: begin
					r.role = ROLE_CODE;
					v = varint_take(b);
					if (v == VI_BAD) begin
						err = ST_INVALID;
					end else if (v == VI_DONE) begin
						val    = vacc;
						vacc   = '0;
						vcount = '0;
						case (val)
							64'(P_IP4):                                  len = 4;
							64'(P_IP6):                                  len = 16;
							64'(P_TCP), 64'(P_UDP):                      len = 2;
							64'(P_WS), 64'(P_WSS), 64'(P_QUIC),
							64'(P_QUICV1), 64'(P_CIRCUIT):               len = 0;
							64'(P_DNS), 64'(P_DNS4), 64'(P_DNS6),
							64'(P_DNSADDR), 64'(P_P2P):                  len = LEN_VARIABLE;
							default:                                     len = LEN_UNKNOWN;
						endcase
						if (len == LEN_UNKNOWN) begin
							err = ST_UNKNOWN;
						end else begin
							cur_code = val[15:0];
							r.code   = cur_code;
							if (len == LEN_VARIABLE) begin
								phase = PH_LEN;
							end else if (len == 0) begin
								r.cend = 1'b1;
								close_component();
							end else begin
								phase     = PH_ADDR;
								remaining = 16'(len);
								offset    = '0;
							end
						end
					end
				end
				PH_LEN: begin
					r.role = ROLE_LEN;
					r.code = cur_code;
					v = varint_take(b);
					if (v == VI_BAD) begin
						err = ST_INVALID;
					end else if (v == VI_DONE) begin
						val    = vacc;
						vacc   = '0;
						vcount = '0;
						if (val > 64'(MAX_ADDRESS_BYTES)) begin
							err = ST_INVALID;
						end else if (val == 64'd0) begin
							r.cend = 1'b1;
							close_component();
						end else begin
							phase     = PH_ADDR;
							remaining = val[15:0];
							offset    = '0;
						end
					end
				end
				default: begin
					r.role = ROLE_ADDR;
					r.code = cur_code;
					r.off  = offset;
					offset = offset + 16'd1;
					if (remaining > 16'd0)
						remaining = remaining - 16'd1;
					if (remaining == 16'd0) begin
						r.cend = 1'b1;
						close_component();
					end
				end
			endcase
			if (err != ST_OK) begin
				fault = err;
				phase = PH_ERR;
			end
		end
		// last byte with a varint or an address still open is a truncation
		if (last && fault == ST_OK && (phase != PH_CODE || vcount != 4'd0)) begin
			fault = ST_INVALID;
			phase = PH_ERR;
		end
		r.status = fault;
		r.count  = seen;
		if (last) begin
			r.done = 1'b1;
			if (fault != ST_OK)
				r.count = '0;
			clear_parse();
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		byte_tag_t want;
		if (!arst_n) begin
			clear_parse();
			expected_tags.delete();
			errors  = 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_tags.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					want = expected_tags.pop_front();
					check_field("byte_role", 16'(want.role), 16'(byte_role));
					check_field("component_number", 16'(want.comp), 16'(component_number));
					check_field("protocol_code", want.code, protocol_code);
					check_field("address_offset", want.off, address_offset);
					check_field("component_end", 16'(want.cend), 16'(component_end));
					check_field("status", 16'(want.status), 16'(status));
					check_field("address_done", 16'(want.done), 16'(address_done));
					check_field("protocol_count", 16'(want.count), 16'(protocol_count));
				end
			end
			if (byte_valid && !byte_stall) begin
				predict_byte_tag(byte_value, last_byte, want);
				expected_tags.push_back(want);
			end
			pending <= expected_tags.size();
		end
	end

endmodule

[dv/multiaddr_binary_stream_validator_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the multiaddr binary stream validator: byte stimulus, result stalls,
// watchdog and verdict. Depends on mbsv_pkg, mbsv_parse_checker and the block's RTL.
module multiaddr_binary_stream_validator_top_tb;
	import mbsv_pkg::*;

	localparam int RANDOM_ITEMS   = 420;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  byte_value;
	logic        last_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  byte_role;
	logic [7:0]  component_number;
	logic [15:0] protocol_code;
	logic [15:0] address_offset;
	logic        component_end;
	logic [1:0]  status;
	logic        address_done;
	logic [7:0]  protocol_count;

	int unsigned errors;
	int unsigned pending;
	int          idle_cycles;
	int          random_items;
	logic        burst;
	logic [7:0]  stim_bytes[$];

	logic [15:0] known_codes[14] = '{P_IP4, P_TCP, P_IP6, P_DNS, P_DNS4, P_DNS6, P_DNSADDR,
		P_UDP, P_CIRCUIT, P_P2P, P_QUIC, P_QUICV1, P_WS, P_WSS};
	logic [15:0] var_codes[5] = '{P_DNS, P_DNS4, P_DNS6, P_DNSADDR, P_P2P};

	multiaddr_binary_stream_validator_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.byte_value       (byte_value),
		.last_byte        (last_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.byte_role        (byte_role),
		.component_number (component_number),
		.protocol_code    (protocol_code),
		.address_offset   (address_offset),
		.component_end    (component_end),
		.status           (status),
		.address_done     (address_done),
		.protocol_count   (protocol_count)
	);

	mbsv_parse_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.byte_value       (byte_value),
		.last_byte        (last_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.byte_role        (byte_role),
		.component_number (component_number),
		.protocol_code    (protocol_code),
		.address_offset   (address_offset),
		.component_end    (component_end),
		.status           (status),
		.address_done     (address_done),
		.protocol_count   (protocol_count),
		.errors           (errors),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random hold-off before each result transaction
	initial begin
		int hold;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = burst ? 0 : $urandom_range(0, 14);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
		end
	end

	task automatic send_byte(input logic [7:0] v, input logic last);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_value <= v;
		last_byte  <= last;
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic send_address();
		burst = ($urandom_range(0, 3) == 0);
		foreach (stim_bytes[i]) begin
			send_byte(stim_bytes[i], i == stim_bytes.size() - 1);
			random_items++;
		end
		stim_bytes.delete();
	endtask

	task automatic push_varint(input logic [63:0] v);
		logic [7:0] b;
		do begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			if (v != 0)
				b[7] = 1'b1;
			stim_bytes.push_back(b);
		end while (v != 0);
	endtask

	task automatic push_component(input logic [15:0] code, input int var_len);
		int size;
		push_varint(64'(code));
		case (code)
			P_IP4:                                        size = 4;
			P_IP6:                                        size = 16;
			P_TCP, P_UDP:                                 size = 2;
			P_DNS, P_DNS4, P_DNS6, P_DNSADDR, P_P2P: begin
				size = var_len;
				push_varint(64'(var_len));
			end
			default:                                      size = 0;
		endcase
		repeat (size) stim_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic push_random(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) stim_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_random_address();
		int          kind;
		int          n;
		logic [63:0] wide;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			n = (kind < 60) ? $urandom_range(1, 3) : $urandom_range(0, 3);
			repeat (n)
				push_component(known_codes[$urandom_range(0, 13)],
					($urandom_range(0, 99) == 0) ? $urandom_range(200, 300)
					                             : $urandom_range(0, 8));
		end
		if (kind >= 60 && kind < 70) begin
			// well-formed address cut short
			if (stim_bytes.size() > 1)
				repeat ($urandom_range(1, stim_bytes.size() - 1)) void'(stim_bytes.pop_back());
		end else if (kind >= 70 && kind < 75) begin
			wide = {$urandom, $urandom};
			wide = wide >> $urandom_range(1, 63);
			push_varint(wide);
			push_random(0, 4);
		end else if (kind >= 75 && kind < 80) begin
			// bad varint in the code or in the length prefix
			if ($urandom_range(0, 1))
				push_varint(64'(var_codes[$urandom_range(0, 4)]));
			if ($urandom_range(0, 1)) begin
				repeat ($urandom_range(1, 7)) stim_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
				stim_bytes.push_back(8'h00);
			end else begin
				repeat (9) stim_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
			end
			push_random(0, 4);
		end else if (kind >= 80 && kind < 85) begin
			push_varint(64'(var_codes[$urandom_range(0, 4)]));
			if ($urandom_range(0, 1)) begin
				push_varint(64'd65536 + 64'($urandom_range(0, 1 << 30)));
				push_random(0, 4);
			end else begin
				// largest legal length, then truncated
				push_varint(64'd65535);
				push_random(1, 6);
			end
		end else if (kind >= 85) begin
			push_random(1, 12);
		end
		if (stim_bytes.size() == 0)
			push_random(1, 4);
	endtask

	initial begin
		arst_n       <= 1'b0;
		byte_valid   <= 1'b0;
		byte_value   <= '0;
		last_byte    <= 1'b0;
		burst        = 1'b0;
		random_items = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ip4 255.0.0.255 then tcp 80
		stim_bytes = '{8'h04, 8'hff, 8'h00, 8'h00, 8'hff, 8'h06, 8'h00, 8'h50};
		send_address();
		// dns with zero length, then wss
		stim_bytes = '{8'h35, 8'h00, 8'hde, 8'h03};
		send_address();
		// non-minimal code varint, trailing byte ignored
		stim_bytes = '{8'h84, 8'h00, 8'h11};
		send_address();
		// unknown code
		stim_bytes = '{8'h7f};
		send_address();
		// dns length of 65536
		stim_bytes = '{8'h35, 8'h80, 8'h80, 8'h04};
		send_address();
		// ip6 cut after one address byte
		stim_bytes = '{8'h29, 8'h01};
		send_address();
		// code varint left open
		stim_bytes = '{8'h91};
		send_address();
		// overlong varint: nine continuation bytes
		repeat (9) stim_bytes.push_back(8'h80);
		send_address();

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			build_random_address();
			send_address();
		end

		byte_valid <= 1'b0;
		// let the checker count the last transaction before polling
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
